/* rtl/urc_pkg.sv */
// Package for the ultrasonic range controller: constants, codes, types and helpers.
`timescale 1ns / 1ps

package urc_pkg;

  // Default counter width for the echo and timeout counters.
  localparam int COUNT_BITS_DEF = 24;

  // Register field widths.
  localparam int SETTLE_W  = 8;
  localparam int TRIG_W    = 8;
  localparam int TIMEOUT_W = 24;
  localparam int OFFSET_W  = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Result field widths.
  localparam int CM_W     = 19;
  localparam int TENTHS_W = 4;

  // Largest reportable whole-centimeter value.
  localparam logic [CM_W-1:0] CM_MAX = {CM_W{1'b1}};

  // Reset values of the registers.
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 8'd2;
  localparam logic [TRIG_W-1:0]    TRIG_RST    = 8'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd1000000;
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 8'd7;

  // width*10/58 == width*5/29: tracked as a running quotient / remainder.
  localparam logic [5:0] DIST_STEP = 6'd5;
  localparam logic [5:0] DIST_DIV  = 6'd29;
  localparam logic [4:0] DIST_REM_ZERO = 5'd0;

  localparam logic [TENTHS_W-1:0] TENTHS_LAST = 4'd9;

  // Register index codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE  = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_OFFSET  = 2'd3
  } reg_idx_t;

  // Input kind codes.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Measurement phases.
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_SETTLE    = 5'b00010,
    PH_TRIG      = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_MEASURE   = 5'b10000
  } phase_t;

  // Status codes.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_TIMEOUT = 1'b1;

  // One result item.
  typedef struct packed {
    logic                trigger_out;
    logic                busy_res;
    logic                done_res;
    logic                status;
    logic [CM_W-1:0]     whole_cm;
    logic [TENTHS_W-1:0] distance_tenths;
  } result_t;

  typedef struct packed {
    logic [4:0]          quo;
    logic [TENTHS_W-1:0] rem;
  } div10_t;

  // Split an 8-bit value into tens and units: x*205 >> 11 is exact below 1029.
  function automatic div10_t div10_u8(input logic [7:0] x);
    logic [15:0] prod;
    logic [7:0]  back;
    div10_t      res;
    prod     = 16'(x) * 16'd205;
    res.quo  = prod[15:11];
    back     = 8'(res.quo) * 8'd10;
    res.rem  = TENTHS_W'(x - back);
    return res;
  endfunction

endpackage

/* rtl/ultrasonic_range_controller_unit.sv */
// Ultrasonic range controller: trigger sequencing, echo width count and distance result.
`timescale 1ns / 1ps

//  channel | ports                                      | item
//  --------+--------------------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_kind, in_echo_level | one 1 us tick or a start
//  out     | out_valid, out_stall, out_* result fields  | state after each input item
//  cfg     | cfg_we, cfg_index, cfg_data                | register write, no read-back
//
//  Every input item gives one registered result item. An item can be accepted every
//  cycle while in_stall is low. Phase update and echo tracking settle in one pass.
//  The distance is kept as a running quotient of width*5/29 split into cm and tenths,
//  so no divider sits in the path. A two-entry output buffer (result register plus
//  skid register) lets one more item in while a result is stalled; in_stall rises
//  only when both entries are full. Synchronous active-low reset returns idle phase,
//  cleared counters and the register defaults.

module ultrasonic_range_controller_unit #(
  parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic                          in_echo_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trigger_out,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_status,
  output logic [urc_pkg::CM_W-1:0]      out_whole_cm,
  output logic [urc_pkg::TENTHS_W-1:0]  out_distance_tenths,
  // configuration
  input  logic                          cfg_we,
  input  logic [urc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urc_pkg::CFG_W-1:0]     cfg_data
);

  // Compare widths: wide enough for both operands.
  localparam int TMO_CMP_W = (COUNT_BITS > urc_pkg::TIMEOUT_W) ? COUNT_BITS
                                                               : urc_pkg::TIMEOUT_W;
  localparam int CM_CMP_W  = (COUNT_BITS > urc_pkg::CM_W) ? COUNT_BITS : urc_pkg::CM_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [urc_pkg::SETTLE_W-1:0]  settle_r;
  logic [urc_pkg::TRIG_W-1:0]    trigger_r;
  logic [urc_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [urc_pkg::OFFSET_W-1:0]  offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r  <= urc_pkg::SETTLE_RST;
      trigger_r <= urc_pkg::TRIG_RST;
      timeout_r <= urc_pkg::TIMEOUT_RST;
      offset_r  <= urc_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      case (urc_pkg::reg_idx_t'(cfg_index))
        urc_pkg::REG_SETTLE:  settle_r  <= cfg_data[urc_pkg::SETTLE_W-1:0];
        urc_pkg::REG_TRIGGER: trigger_r <= cfg_data[urc_pkg::TRIG_W-1:0];
        urc_pkg::REG_TIMEOUT: timeout_r <= cfg_data[urc_pkg::TIMEOUT_W-1:0];
        urc_pkg::REG_OFFSET:  offset_r  <= cfg_data[urc_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Measurement state.
  urc_pkg::phase_t                phase_r, phase_nxt;
  logic [7:0]                     ptimer_r, ptimer_nxt;
  logic [COUNT_BITS-1:0]          wait_r, wait_nxt;
  logic [COUNT_BITS-1:0]          pulse_r, pulse_nxt;
  logic                           echo_prev_r, echo_prev_nxt;
  // Running distance: remainder of 5*width mod 29, plus quotient+offset in cm/tenths.
  logic [4:0]                     drem_r, drem_nxt;
  logic [COUNT_BITS-1:0]          dcm_r, dcm_nxt;
  logic [urc_pkg::TENTHS_W-1:0]   dtn_r, dtn_nxt;

  logic                           in_acc;
  logic                           rise, fall;
  logic                           pulse_inc;
  logic [5:0]                     drem_sum;
  logic                           timed_out;
  logic [TMO_CMP_W-1:0]           wait_cmp, tmo_cmp;
  logic [CM_CMP_W-1:0]            cm_wide;
  urc_pkg::div10_t                off_split;
  urc_pkg::result_t               res_new;

  assign rise      = !echo_prev_r && in_echo_level;
  assign fall      = echo_prev_r && !in_echo_level;
  assign off_split = urc_pkg::div10_u8(offset_r);
  assign wait_cmp  = TMO_CMP_W'(wait_nxt);
  assign tmo_cmp   = TMO_CMP_W'(timeout_r);
  assign timed_out = (wait_cmp >= tmo_cmp) || (wait_nxt == CNT_MAX);
  assign drem_sum  = {1'b0, drem_r} + urc_pkg::DIST_STEP;
  assign cm_wide   = CM_CMP_W'(dcm_nxt);

  always_comb begin
    phase_nxt     = phase_r;
    ptimer_nxt    = ptimer_r;
    wait_nxt      = wait_r;
    pulse_nxt     = pulse_r;
    echo_prev_nxt = echo_prev_r;
    drem_nxt      = drem_r;
    dcm_nxt       = dcm_r;
    dtn_nxt       = dtn_r;
    pulse_inc     = 1'b0;

    res_new                 = '0;
    res_new.status          = urc_pkg::STAT_OK;

    if (in_kind == urc_pkg::KIND_START) begin
      // Start only takes effect from idle; echo sample is ignored.
      if (phase_r == urc_pkg::PH_IDLE) begin
        ptimer_nxt = '0;
        wait_nxt   = '0;
        pulse_nxt  = '0;
        phase_nxt  = (settle_r == '0) ? urc_pkg::PH_TRIG : urc_pkg::PH_SETTLE;
      end
    end else begin
      echo_prev_nxt = in_echo_level;
      case (phase_r)
        urc_pkg::PH_SETTLE: begin
          ptimer_nxt = ptimer_r + 8'd1;
          if (ptimer_nxt >= settle_r) begin
            phase_nxt  = urc_pkg::PH_TRIG;
            ptimer_nxt = '0;
          end
        end
        urc_pkg::PH_TRIG: begin
          ptimer_nxt = ptimer_r + 8'd1;
          if (ptimer_nxt >= trigger_r) begin
            phase_nxt  = urc_pkg::PH_WAIT_RISE;
            ptimer_nxt = '0;
            wait_nxt   = '0;
            pulse_nxt  = '0;
          end
        end
        urc_pkg::PH_WAIT_RISE, urc_pkg::PH_MEASURE: begin
          if (wait_r != CNT_MAX) begin
            wait_nxt = wait_r + COUNT_BITS'(1);
          end
          if (phase_r == urc_pkg::PH_WAIT_RISE) begin
            if (rise) begin
              // Width restarts; distance starts from the offset.
              phase_nxt = urc_pkg::PH_MEASURE;
              pulse_nxt = '0;
              drem_nxt  = urc_pkg::DIST_REM_ZERO;
              dcm_nxt   = COUNT_BITS'(off_split.quo);
              dtn_nxt   = off_split.rem;
            end
          end else if (fall || in_echo_level) begin
            pulse_inc = (pulse_r != CNT_MAX);
          end

          if (pulse_inc) begin
            pulse_nxt = pulse_r + COUNT_BITS'(1);
            if (drem_sum >= urc_pkg::DIST_DIV) begin
              drem_nxt = 5'(drem_sum - urc_pkg::DIST_DIV);
              if (dtn_r == urc_pkg::TENTHS_LAST) begin
                dtn_nxt = '0;
                dcm_nxt = dcm_r + COUNT_BITS'(1);
              end else begin
                dtn_nxt = dtn_r + urc_pkg::TENTHS_W'(1);
              end
            end else begin
              drem_nxt = drem_sum[4:0];
            end
          end

          if (phase_r == urc_pkg::PH_MEASURE && fall) begin
            res_new.done_res = 1'b1;
            res_new.status   = urc_pkg::STAT_OK;
            phase_nxt        = urc_pkg::PH_IDLE;
            if (cm_wide > CM_CMP_W'(urc_pkg::CM_MAX)) begin
              res_new.whole_cm        = urc_pkg::CM_MAX;
              res_new.distance_tenths = urc_pkg::TENTHS_LAST;
            end else begin
              res_new.whole_cm        = cm_wide[urc_pkg::CM_W-1:0];
              res_new.distance_tenths = dtn_nxt;
            end
          end else if (timed_out) begin
            res_new.done_res = 1'b1;
            res_new.status   = urc_pkg::STAT_TIMEOUT;
            phase_nxt        = urc_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    res_new.trigger_out = (phase_nxt == urc_pkg::PH_TRIG);
    res_new.busy_res    = (phase_nxt != urc_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= urc_pkg::PH_IDLE;
      ptimer_r    <= '0;
      wait_r      <= '0;
      pulse_r     <= '0;
      echo_prev_r <= 1'b0;
      drem_r      <= urc_pkg::DIST_REM_ZERO;
      dcm_r       <= '0;
      dtn_r       <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      ptimer_r    <= ptimer_nxt;
      wait_r      <= wait_nxt;
      pulse_r     <= pulse_nxt;
      echo_prev_r <= echo_prev_nxt;
      drem_r      <= drem_nxt;
      dcm_r       <= dcm_nxt;
      dtn_r       <= dtn_nxt;
    end
  end

  // Output buffer: result register plus one skid entry.
  urc_pkg::result_t out_r, skid_r;
  logic             out_vld_r, skid_vld_r;
  logic             out_take;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_take) begin
        out_r <= res_new;
      end else begin
        skid_r <= res_new;
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_trigger_out     = out_r.trigger_out;
  assign out_busy_res        = out_r.busy_res;
  assign out_done_res        = out_r.done_res;
  assign out_status          = out_r.status;
  assign out_whole_cm        = out_r.whole_cm;
  assign out_distance_tenths = out_r.distance_tenths;

endmodule

/* tb/ultrasonic_range_controller_unit_tb.sv */
// Self-checking testbench for the ultrasonic range controller: directed table, then random runs.
`timescale 1ns / 1ps

module ultrasonic_range_controller_unit_tb;
  import urc_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int N_SETS = 7;
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_SAT = '1;

  // One line of the directed table: a register write or an input item.
  typedef struct {
    bit                 is_cfg;
    reg_idx_t           idx;
    logic [CFG_W-1:0]   val;
    logic               kind;
    logic               echo;
    bit                 typed;
    result_t            want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_TICK;
  logic in_echo_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_trigger_out;
  logic out_busy_res;
  logic out_done_res;
  logic out_status;
  logic [CM_W-1:0] out_whole_cm;
  logic [TENTHS_W-1:0] out_distance_tenths;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SETTLE;
  logic [CFG_W-1:0] cfg_data = '0;

  ultrasonic_range_controller_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trigger_out    (out_trigger_out),
    .out_busy_res       (out_busy_res),
    .out_done_res       (out_done_res),
    .out_status         (out_status),
    .out_whole_cm       (out_whole_cm),
    .out_distance_tenths(out_distance_tenths),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: register copies and the ranging sequencer.
  logic [SETTLE_W-1:0]  settle_len  = SETTLE_RST;
  logic [TRIG_W-1:0]    trig_len    = TRIG_RST;
  logic [TIMEOUT_W-1:0] timeout_len = TIMEOUT_RST;
  logic [OFFSET_W-1:0]  offset_add  = OFFSET_RST;
  phase_t               cur_phase   = PH_IDLE;
  logic [7:0]           step_cnt    = '0;
  cnt_t                 since_trig  = '0;
  cnt_t                 echo_width  = '0;
  logic                 echo_last   = 1'b0;

  // Echo shape of the measurement in flight: hold the old level, go low, then
  // a high pulse of high_left ticks after the rising tick.
  int hold_left = 0;
  int low_left = 0;
  int high_left = 0;

  result_t pending_res[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int ok_count = 0;
  int tmo_count = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int sink_hold = 0;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic result_t res_of(input logic trig, input logic busy, input logic done,
                                     input logic stat, input logic [CM_W-1:0] cm,
                                     input logic [TENTHS_W-1:0] tn);
    result_t r;
    r.trigger_out = trig;
    r.busy_res = busy;
    r.done_res = done;
    r.status = stat;
    r.whole_cm = cm;
    r.distance_tenths = tn;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    step_row_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    s.kind = KIND_TICK;
    s.echo = 1'b0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_row_t item_row(input logic kind, input logic echo, input bit typed,
                                         input result_t want);
    step_row_t s;
    s.is_cfg = 1'b0;
    s.idx = REG_SETTLE;
    s.val = '0;
    s.kind = kind;
    s.echo = echo;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // Advance the ranging sequencer by one item and form its result.
  task automatic predict_range(input logic kind, input logic echo, output result_t r);
    logic rise;
    logic fall;
    logic done;
    logic stat;
    longint unsigned total;
    r = '0;
    done = 1'b0;
    stat = STAT_OK;
    if (kind == KIND_START) begin
      // start while busy is dropped; the start's echo bit never counts as a level
      if (cur_phase == PH_IDLE) begin
        step_cnt = '0;
        since_trig = '0;
        echo_width = '0;
        cur_phase = (settle_len == '0) ? PH_TRIG : PH_SETTLE;
      end
    end else begin
      rise = !echo_last && echo;
      fall = echo_last && !echo;
      case (cur_phase)
        PH_SETTLE: begin
          step_cnt = step_cnt + 8'd1;
          if (step_cnt >= settle_len) begin
            cur_phase = PH_TRIG;
            step_cnt = '0;
          end
        end
        PH_TRIG: begin
          // a zero trigger length still holds the pulse for one tick
          step_cnt = step_cnt + 8'd1;
          if (step_cnt >= trig_len) begin
            cur_phase = PH_WAIT_RISE;
            step_cnt = '0;
            since_trig = '0;
            echo_width = '0;
          end
        end
        PH_WAIT_RISE, PH_MEASURE: begin
          if (since_trig != CNT_SAT) since_trig = since_trig + 1'b1;
          if (cur_phase == PH_WAIT_RISE) begin
            // an echo already high when the wait opens is not a rising edge
            if (rise) begin
              cur_phase = PH_MEASURE;
              echo_width = '0;
            end
          end else if (fall) begin
            if (echo_width != CNT_SAT) echo_width = echo_width + 1'b1;
            total = echo_width;
            total = total * 10 / 58 + offset_add;
            if (total / 10 > CM_MAX) begin
              r.whole_cm = CM_MAX;
              r.distance_tenths = TENTHS_LAST;
            end else begin
              r.whole_cm = CM_W'(total / 10);
              r.distance_tenths = TENTHS_W'(total % 10);
            end
            done = 1'b1;
            cur_phase = PH_IDLE;
          end else if (echo) begin
            if (echo_width != CNT_SAT) echo_width = echo_width + 1'b1;
          end
          // a falling edge on the timeout tick wins over the timeout
          if (!done && (since_trig >= timeout_len || since_trig == CNT_SAT)) begin
            done = 1'b1;
            stat = STAT_TIMEOUT;
            r.whole_cm = '0;
            r.distance_tenths = '0;
            cur_phase = PH_IDLE;
          end
        end
        default: ;
      endcase
      echo_last = echo;
    end
    r.trigger_out = (cur_phase == PH_TRIG);
    r.busy_res = (cur_phase != PH_IDLE);
    r.done_res = done;
    r.status = stat;
  endtask

  // Present one item, hold it through stalls, then record what it should give.
  task automatic drive_item(input logic kind, input logic echo, input bit typed,
                            input result_t want);
    int gap;
    result_t calc;
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_echo_level <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_range(kind, echo, calc);
    pending_res.push_back(typed ? want : calc);
    items_sent++;
  endtask

  task automatic wait_results_home();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SETTLE:  settle_len = val[SETTLE_W-1:0];
      REG_TRIGGER: trig_len = val[TRIG_W-1:0];
      REG_TIMEOUT: timeout_len = val[TIMEOUT_W-1:0];
      REG_OFFSET:  offset_add = val[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // Choose the next random item from the sequencer's current phase, so most
  // runs are complete trigger / echo cycles with occasional glitches.
  task automatic pick_item(input bit may_start, output logic kind, output logic echo);
    kind = KIND_TICK;
    echo = 1'($urandom_range(0, 1));
    case (cur_phase)
      PH_IDLE: begin
        if (may_start && $urandom_range(0, 4) != 0) begin
          kind = KIND_START;
          hold_left = $urandom_range(0, 3);
          low_left = $urandom_range(0, 4);
          high_left = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 1500)
                                                  : $urandom_range(0, 40);
        end
      end
      PH_WAIT_RISE: begin
        if (hold_left != 0) begin
          echo = echo_last;
          hold_left--;
        end else if (low_left != 0) begin
          echo = 1'b0;
          low_left--;
        end else begin
          echo = !echo_last;
        end
      end
      PH_MEASURE: begin
        echo = (high_left != 0);
        if (high_left != 0) high_left--;
      end
      default: ;
    endcase
    if (cur_phase != PH_IDLE) begin
      if ($urandom_range(0, 24) == 0) kind = KIND_START;
      else if ($urandom_range(0, 19) == 0) echo = 1'($urandom_range(0, 1));
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_res.size() == 0) begin
      report_error("result item with no input item pending");
      return;
    end
    want = pending_res.pop_front();
    results_seen++;
    if (out_trigger_out !== want.trigger_out)
      report_error($sformatf("result %0d trigger_out %b, want %b", results_seen,
                             out_trigger_out, want.trigger_out));
    if (out_busy_res !== want.busy_res)
      report_error($sformatf("result %0d busy_res %b, want %b", results_seen,
                             out_busy_res, want.busy_res));
    if (out_done_res !== want.done_res)
      report_error($sformatf("result %0d done_res %b, want %b", results_seen,
                             out_done_res, want.done_res));
    if (out_status !== want.status)
      report_error($sformatf("result %0d status %b, want %b", results_seen,
                             out_status, want.status));
    if (out_whole_cm !== want.whole_cm)
      report_error($sformatf("result %0d whole_cm %0d, want %0d", results_seen,
                             out_whole_cm, want.whole_cm));
    if (out_distance_tenths !== want.distance_tenths)
      report_error($sformatf("result %0d distance_tenths %0d, want %0d", results_seen,
                             out_distance_tenths, want.distance_tenths));
    if (want.done_res) begin
      if (want.status == STAT_OK) ok_count++;
      else tmo_count++;
    end
  endtask

  // Result side: take results and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (sink_hold == 0) sink_hold = pick_gap(sink_idle_on);
    if (sink_hold != 0) begin
      out_stall <= 1'b1;
      sink_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    step_row_t rows[$];
    result_t idle_res;
    result_t trig_res;
    result_t ok_zero;
    result_t timed_out;
    result_t ok_offset;
    logic kind;
    logic echo;
    int budget;
    int counted;
    idle_res  = res_of(1'b0, 1'b0, 1'b0, STAT_OK, '0, '0);
    trig_res  = res_of(1'b1, 1'b1, 1'b0, STAT_OK, '0, '0);
    ok_zero   = res_of(1'b0, 1'b0, 1'b1, STAT_OK, '0, '0);
    timed_out = res_of(1'b0, 1'b0, 1'b1, STAT_TIMEOUT, '0, '0);
    ok_offset = res_of(1'b0, 1'b0, 1'b1, STAT_OK, 19'd25, 4'd5);

    // tick in idle right after reset
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b1, idle_res));
    // no settle, one-tick trigger, short timeout
    rows.push_back(cfg_row(REG_SETTLE, 24'd0));
    rows.push_back(cfg_row(REG_TRIGGER, 24'd1));
    rows.push_back(cfg_row(REG_TIMEOUT, 24'd6));
    rows.push_back(cfg_row(REG_OFFSET, 24'd0));
    rows.push_back(item_row(KIND_START, 1'b1, 1'b1, trig_res));
    rows.push_back(item_row(KIND_START, 1'b0, 1'b1, trig_res));   // start while busy
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));    // echo high at trigger end
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));    // still high: no edge
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_START, 1'b1, 1'b0, idle_res));   // its echo bit is ignored
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));    // rising edge
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b1, ok_zero));     // falling edge, width 2
    // zero timeout: first tick after the trigger ends the cycle
    rows.push_back(cfg_row(REG_TIMEOUT, 24'd0));
    rows.push_back(item_row(KIND_START, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b1, timed_out));
    // falling edge lands on the timeout tick
    rows.push_back(cfg_row(REG_TIMEOUT, 24'd3));
    rows.push_back(item_row(KIND_START, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b1, ok_zero));
    // largest offset and timeout
    rows.push_back(cfg_row(REG_OFFSET, 24'd255));
    rows.push_back(cfg_row(REG_TIMEOUT, 24'hFFFFFF));
    rows.push_back(item_row(KIND_START, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b1, 1'b0, idle_res));
    rows.push_back(item_row(KIND_TICK, 1'b0, 1'b1, ok_offset));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_results_home();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        drive_item(rows[i].kind, rows[i].echo, rows[i].typed, rows[i].want);
      end
    end

    // Random runs, one register setting each: defaults, both extremes, then
    // random small settings and short timeouts so that timeouts and echoes mix.
    for (int s = 0; s < N_SETS; s++) begin
      wait_results_home();
      case (s)
        0: begin
          write_reg(REG_SETTLE, 24'(SETTLE_RST));
          write_reg(REG_TRIGGER, 24'(TRIG_RST));
          write_reg(REG_TIMEOUT, 24'(TIMEOUT_RST));
          write_reg(REG_OFFSET, 24'(OFFSET_RST));
          budget = 200;
        end
        1: begin
          write_reg(REG_SETTLE, 24'd0);
          write_reg(REG_TRIGGER, 24'd0);
          write_reg(REG_TIMEOUT, 24'd0);
          write_reg(REG_OFFSET, 24'd0);
          budget = 150;
        end
        2: begin
          write_reg(REG_SETTLE, 24'd255);
          write_reg(REG_TRIGGER, 24'd255);
          write_reg(REG_TIMEOUT, 24'hFFFFFF);
          write_reg(REG_OFFSET, 24'd255);
          budget = 400;
        end
        default: begin
          write_reg(REG_SETTLE, 24'($urandom_range(0, 4)));
          write_reg(REG_TRIGGER, 24'($urandom_range(0, 4)));
          write_reg(REG_TIMEOUT, 24'($urandom_range(1, 80)));
          write_reg(REG_OFFSET, 24'($urandom_range(0, 255)));
          budget = 200;
        end
      endcase
      src_idle_on = ($urandom_range(0, 2) != 0);
      sink_idle_on = ($urandom_range(0, 2) != 0);
      counted = 0;
      // past the budget no new start is issued; run the open cycle out
      while (counted < budget || cur_phase != PH_IDLE) begin
        pick_item(counted < budget, kind, echo);
        if (!((kind == KIND_TICK && cur_phase == PH_IDLE) ||
              (kind == KIND_START && cur_phase != PH_IDLE)))
          counted++;
        drive_item(kind, echo, 1'b0, idle_res);
      end
    end

    wait_results_home();
    repeat (10) @(posedge clk);
    $display("Sent %0d items: a directed table, then %0d random register settings.",
             items_sent, N_SETS);
    $display("Finished measurements: %0d with a distance, %0d timed out.", ok_count, tmo_count);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
